### sv/gbs_pkg.sv
// shared types and constants for the greedy box suppression core
package gbs_pkg;

  // fixed field widths
  localparam int THR_W    = 9;
  localparam int SLOT_W   = 7;
  localparam int IDX_W    = 16;
  localparam int SCALE_SH = 8;

  localparam logic [THR_W-1:0] THR_RESET = 9'd115;
  localparam logic [IDX_W-1:0] IDX_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } gbs_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } gbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } gbs_stat_t;

endpackage

### sv/gbs_box_if.sv
// box input channel and result output channel
interface gbs_box_if
  import gbs_pkg::*;
#(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         frame_start;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-2:0]        box_w;
  logic [COORD_BITS-2:0]        box_h;

  modport source (output valid, frame_start, box_x, box_y, box_w, box_h, input ready);
  modport sink (input valid, frame_start, box_x, box_y, box_w, box_h, output ready);
endinterface

interface gbs_result_if
  import gbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              keep;
  logic [SLOT_W-1:0] kept_slot;
  logic [IDX_W-1:0]  candidate_index;
  logic              store_full;

  modport source (output valid, keep, kept_slot, candidate_index, store_full, input ready);
  modport sink (input valid, keep, kept_slot, candidate_index, store_full, output ready);
endinterface

### sv/gbs_ctrl.sv
// sequencing state machine: accept, scan kept store, drain compares, emit result
module gbs_ctrl
  import gbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gbs_stat_t stat,
  output gbs_cmd_t  cmd
);

  gbs_state_t state;
  gbs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.count_zero || stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.step = !stat.count_zero;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.finish = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### sv/gbs_dp.sv
// datapath: kept box store, compare pipeline, counters and result register
module gbs_dp
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 16
)(
  input  logic                         clk,
  input  logic                         rst,
  input  gbs_cmd_t                     cmd,
  output gbs_stat_t                    stat,
  input  logic [THR_W-1:0]             threshold,
  input  logic                         in_frame_start,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic [COORD_BITS-2:0]        in_w,
  input  logic [COORD_BITS-2:0]        in_h,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_keep,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [IDX_W-1:0]             out_index,
  output logic                         out_full
);

  localparam int CB     = COORD_BITS;
  localparam int LW     = CB - 1;
  localparam int AREA_W = 2 * LW;
  localparam int UW     = AREA_W + 1;
  localparam int PW     = THR_W + UW;
  localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW     = $clog2(MAX_KEPT + 1);
  localparam int MW     = 2 * CB + 2 * LW + AREA_W;

  function automatic logic [LW-1:0] overlap(input logic signed [CB-1:0] a0,
                                            input logic [LW-1:0] alen,
                                            input logic signed [CB-1:0] b0,
                                            input logic [LW-1:0] blen);
    logic signed [CB:0] ea;
    logic signed [CB:0] eb;
    logic signed [CB:0] hi;
    logic signed [CB:0] lo;
    logic signed [CB:0] diff;
    ea   = {a0[CB-1], a0} + $signed({2'b00, alen});
    eb   = {b0[CB-1], b0} + $signed({2'b00, blen});
    hi   = (ea < eb) ? ea : eb;
    lo   = (a0 > b0) ? {a0[CB-1], a0} : {b0[CB-1], b0};
    diff = hi - lo;
    return (hi > lo) ? diff[LW-1:0] : '0;
  endfunction

  // current box
  logic signed [CB-1:0] cur_x, cur_y;
  logic [LW-1:0]        cur_w, cur_h;
  logic [AREA_W-1:0]    cur_area;
  logic [IDX_W-1:0]     cur_idx;
  logic                 suppress;

  logic [CW-1:0]    kept_count;
  logic [IDX_W-1:0] seen_count;
  logic [IDX_W-1:0] idx_base;
  logic [AW-1:0]    addr;
  logic             store_room;

  logic [MW-1:0] mem [MAX_KEPT];
  logic [MW-1:0] rd_word;

  // compare pipeline
  logic v1, v2, v3, v4, v5;
  logic [LW-1:0]     s2_ox, s2_oy;
  logic [AREA_W-1:0] s2_karea, s3_karea, s3_inter, s4_inter;
  logic [UW-1:0]     s4_union;
  logic [PW-1:0]     s5_prod, s5_lhs;

  logic signed [CB-1:0] k_x, k_y;
  logic [LW-1:0]        k_w, k_h;
  logic [AREA_W-1:0]    k_area;

  assign {k_x, k_y, k_w, k_h, k_area} = rd_word;
  assign idx_base   = in_frame_start ? '0 : seen_count;
  assign store_room = kept_count < CW'(MAX_KEPT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x   <= in_x;
      cur_y   <= in_y;
      cur_w   <= in_w;
      cur_h   <= in_h;
      cur_idx <= idx_base;
    end
    cur_area <= AREA_W'(cur_w) * AREA_W'(cur_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      seen_count <= '0;
    end else if (cmd.load) begin
      if (in_frame_start) kept_count <= '0;
      seen_count <= (idx_base == IDX_MAX) ? idx_base : idx_base + 1'b1;
    end else if (cmd.finish && !suppress && store_room) begin
      kept_count <= kept_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= '0;
    end else if (cmd.step) begin
      addr <= addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !suppress && store_room) begin
      mem[kept_count[AW-1:0]] <= {cur_x, cur_y, cur_w, cur_h, cur_area};
    end
    if (cmd.step) begin
      rd_word <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= cmd.step;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s2_ox    <= overlap(cur_x, cur_w, k_x, k_w);
    s2_oy    <= overlap(cur_y, cur_h, k_y, k_h);
    s2_karea <= k_area;
    s3_inter <= AREA_W'(s2_ox) * AREA_W'(s2_oy);
    s3_karea <= s2_karea;
    s4_union <= UW'(cur_area) + UW'(s3_karea) - UW'(s3_inter);
    s4_inter <= s3_inter;
    s5_prod  <= PW'(threshold) * PW'(s4_union);
    s5_lhs   <= PW'({s4_inter, {SCALE_SH{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      suppress <= 1'b0;
    end else if (v5 && (s5_lhs > s5_prod)) begin
      suppress <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_keep  <= !suppress;
      out_index <= cur_idx;
      if (suppress) begin
        out_slot <= '0;
        out_full <= 1'b0;
      end else if (store_room) begin
        out_slot <= SLOT_W'(kept_count);
        out_full <= 1'b0;
      end else begin
        out_slot <= SLOT_W'(MAX_KEPT);
        out_full <= 1'b1;
      end
    end
  end

  assign stat.count_zero = (kept_count == '0);
  assign stat.scan_last  = (CW'(addr) == kept_count - 1'b1);
  assign stat.pipe_busy  = v1 | v2 | v3 | v4 | v5;
  assign stat.out_free   = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(MAX_KEPT))
    else $error("kept count past store depth");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.pipe_busy)
    else $error("result taken with compares in flight");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (CW'(addr) < kept_count))
    else $error("store read beyond kept entries");

endmodule

### sv/greedy_box_suppression_core.sv
// top level of the greedy box suppression core
//
//  channel   dir  payload                                          transfer
//  box_in    in   frame_start, box_x, box_y, box_w, box_h           valid & ready
//  result    out  keep, kept_slot, candidate_index, store_full      valid & ready
//  cfg       in   cfg_wdata = iou_threshold (9 bits)                cfg_we
//
//  one box in the compare path at a time: the next box is accepted only once the result
//    of the last is registered; the single read port of the kept store limits the scan
//    to one stored box compared per cycle
//  compare pipeline stages s2 to s5 follow the store read
//  rst is synchronous; threshold comes back as 115, kept and seen counts clear
//  a waiting result blocks only the end of the next box, not its acceptance
module greedy_box_suppression_core
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 16
)(
  input  logic             clk,
  input  logic             rst,
  gbs_box_if.sink          box_in,
  gbs_result_if.source     result,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  logic [THR_W-1:0] iou_threshold;
  gbs_cmd_t         cmd;
  gbs_stat_t        stat;

  // threshold register; the user must write it only between words, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= THR_RESET;
    end else if (cfg_we) begin
      iou_threshold <= cfg_wdata;
    end
  end

  // sequencer
  gbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (box_in.valid),
    .in_ready (box_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, overlap pipeline and result register
  gbs_dp #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .threshold      (iou_threshold),
    .in_frame_start (box_in.frame_start),
    .in_x           (box_in.box_x),
    .in_y           (box_in.box_y),
    .in_w           (box_in.box_w),
    .in_h           (box_in.box_h),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_keep       (result.keep),
    .out_slot       (result.kept_slot),
    .out_index      (result.candidate_index),
    .out_full       (result.store_full)
  );

endmodule

### bench/greedy_box_suppression_core_tb.sv
// self-checking testbench for the greedy box suppression core
module greedy_box_suppression_core_tb;
  import gbs_pkg::*;

  localparam int CB           = 16;    // coordinate width
  localparam int LW           = CB - 1;
  localparam int MAX_KEPT     = 64;    // depth of the kept store
  localparam int PHASE_BOXES  = 65;    // least number of random boxes per threshold setting
  localparam int HOLD_CYCLES  = 500;   // one long receiver hold-off
  localparam int DRAIN_CYCLES = 100;   // settle time after the last result word
  localparam int STALL_LIMIT  = 4000;  // cycles without any handshake before giving up
  localparam int MAX_REPORTS  = 20;

  // one box word as offered on the input channel
  typedef struct packed {
    logic                 frame_start;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [CB-2:0]        w;
    logic [CB-2:0]        h;
  } box_word_t;

  localparam int BOX_W = $bits(box_word_t);

  // one result word, field order matches the output channel
  typedef struct packed {
    logic              keep;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  idx;
    logic              full;
  } verdict_t;

  typedef enum logic {STEP_BOX, STEP_CFG} step_kind_t;

  // one row of the directed table
  typedef struct {
    step_kind_t       kind;
    logic [THR_W-1:0] thr;
    box_word_t        box;
    logic             known;  // row carries a hand-written expected word
    verdict_t         want;
  } step_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  gbs_box_if #(.COORD_BITS(CB)) box_ch ();
  gbs_result_if                 res_ch ();

  greedy_box_suppression_core #(
    .MAX_KEPT  (MAX_KEPT),
    .COORD_BITS(CB)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .box_in   (box_ch),
    .result   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // suppression predictor: its own copy of the kept list, counters and threshold
  // ---------------------------------------------------------------------------
  longint           kept_x    [MAX_KEPT];
  longint           kept_y    [MAX_KEPT];
  longint           kept_w    [MAX_KEPT];
  longint           kept_h    [MAX_KEPT];
  longint           kept_area [MAX_KEPT];
  int               kept_n;
  int               seen_n;
  logic [THR_W-1:0] thr_model;

  // result words still owed by the block, oldest first
  verdict_t pending_verdicts [$];

  int errors;
  int burst_left;
  bit hold_req;   // asks the receiver for one long hold-off

  // length of the overlap of two 1-d spans, 0 when they do not meet
  function automatic longint span_overlap(longint a0, longint alen, longint b0, longint blen);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // decide one box against the kept list and update the list
  function automatic verdict_t judge_box(input box_word_t b);
    verdict_t v;
    longint   bx, by, bw, bh, area, inter, uni;
    bit       survives;
    int       j;
    if (b.frame_start) begin
      kept_n = 0;
      seen_n = 0;
    end
    bx       = $signed(b.x);
    by       = $signed(b.y);
    bw       = b.w;
    bh       = b.h;
    area     = bw * bh;
    survives = 1'b1;
    // iou > thr/256 compared without division; zero union never suppresses
    for (j = 0; j < kept_n; j++) begin
      inter = span_overlap(bx, bw, kept_x[j], kept_w[j]) *
              span_overlap(by, bh, kept_y[j], kept_h[j]);
      uni   = area + kept_area[j] - inter;
      if (inter * 256 > longint'(thr_model) * uni) survives = 1'b0;
    end
    v.idx  = seen_n[IDX_W-1:0];
    if (seen_n < 65535) seen_n++;
    v.keep = survives;
    v.slot = '0;
    v.full = 1'b0;
    if (survives) begin
      if (kept_n < MAX_KEPT) begin
        v.slot            = kept_n[SLOT_W-1:0];
        kept_x[kept_n]    = bx;
        kept_y[kept_n]    = by;
        kept_w[kept_n]    = bw;
        kept_h[kept_n]    = bh;
        kept_area[kept_n] = area;
        kept_n++;
      end else begin
        // store full: reported as kept but not remembered
        v.slot = MAX_KEPT[SLOT_W-1:0];
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  // table row builders
  function automatic step_t box_step(logic fs, int x, int y, int w, int h);
    step_t s;
    s.kind            = STEP_BOX;
    s.thr             = '0;
    s.box.frame_start = fs;
    s.box.x           = x[CB-1:0];
    s.box.y           = y[CB-1:0];
    s.box.w           = w[CB-2:0];
    s.box.h           = h[CB-2:0];
    s.known           = 1'b0;
    s.want            = '0;
    return s;
  endfunction

  function automatic step_t known_step(logic fs, int x, int y, int w, int h,
                                       logic keep, int slot, int idx);
    step_t s;
    s           = box_step(fs, x, y, w, h);
    s.known     = 1'b1;
    s.want.keep = keep;
    s.want.slot = slot[SLOT_W-1:0];
    s.want.idx  = idx[IDX_W-1:0];
    s.want.full = 1'b0;
    return s;
  endfunction

  function automatic step_t cfg_step(logic [THR_W-1:0] t);
    step_t s;
    s      = box_step(1'b0, 0, 0, 0, 0);
    s.kind = STEP_CFG;
    s.thr  = t;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps; valid stays high across
  // back-to-back words and is lowered only when a gap starts
  // ---------------------------------------------------------------------------
  task automatic offer_box(input box_word_t b, input logic known, input verdict_t want);
    int       gap;
    verdict_t v;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        box_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    box_ch.valid       <= 1'b1;
    box_ch.frame_start <= b.frame_start;
    box_ch.box_x       <= b.x;
    box_ch.box_y       <= b.y;
    box_ch.box_w       <= b.w;
    box_ch.box_h       <= b.h;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    // word taken at this edge
    v = judge_box(b);
    pending_verdicts.insert(pending_verdicts.size(), known ? want : v);
  endtask

  // threshold changes only with the block idle: input quiet, every result back
  task automatic set_threshold(input logic [THR_W-1:0] t);
    box_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_model  = t;
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // receiver: checks every result word and stalls on its own pattern
  // ---------------------------------------------------------------------------
  initial begin : result_side
    verdict_t got;
    verdict_t want;
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       pulse;
    res_ch.ready <= 1'b0;
    mode_left = 0;
    hold_left = 0;
    pulse     = 0;
    mode      = RX_OPEN;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.keep, res_ch.kept_slot, res_ch.candidate_index, res_ch.store_full};
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"%0t: result word with no box word waiting:",
                      " keep=%0d slot=%0d index=%0d full=%0d"},
                     $time, got.keep, got.slot, got.idx, got.full);
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: result word mismatch: expected keep=%0d slot=%0d index=%0d full=%0d,",
                        " actual keep=%0d slot=%0d index=%0d full=%0d"},
                       $time, want.keep, want.slot, want.idx, want.full,
                       got.keep, got.slot, got.idx, got.full);
          end
        end
      end
      // long hold-off: block fills up and has to stall its input
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      pulse++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_COIN:   res_ch.ready <= 1'($urandom_range(1));
          RX_SPARSE: res_ch.ready <= ($urandom_range(3) == 0);
          default:   res_ch.ready <= (pulse % 4 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any word moving on either channel
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_t            steps [$];
    box_word_t        b;
    logic [THR_W-1:0] thr;
    int               p, i, c, k, sent, nbox, ncl, sz;
    int               cx [4];
    int               cy [4];
    int               csz [4];

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= THR_RESET;
    box_ch.valid       <= 1'b0;
    box_ch.frame_start <= 1'b0;
    box_ch.box_x       <= '0;
    box_ch.box_y       <= '0;
    box_ch.box_w       <= '0;
    box_ch.box_h       <= '0;
    errors     = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    kept_n     = 0;
    seen_n     = 0;
    thr_model  = THR_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table, threshold starts at its reset value
    // same box twice: iou of 1 drops the second
    steps.insert(steps.size(), known_step(1'b1, 0, 0, 160, 160, 1'b1, 0, 0));
    steps.insert(steps.size(), known_step(1'b0, 0, 0, 160, 160, 1'b0, 0, 1));
    // extreme corners and sizes, far from everything kept
    steps.insert(steps.size(), known_step(1'b0, -32768, -32768, 32767, 32767, 1'b1, 1, 2));
    steps.insert(steps.size(), known_step(1'b0, 32767, 32767, 32767, 32767, 1'b1, 2, 3));
    // degenerate boxes, two empty boxes on each other give a zero union
    steps.insert(steps.size(), box_step(1'b0, 0, 0, 0, 160));
    steps.insert(steps.size(), box_step(1'b0, 0, 0, 0, 0));
    steps.insert(steps.size(), box_step(1'b0, 0, 0, 0, 0));
    // half overlap stays, larger overlap goes
    steps.insert(steps.size(), box_step(1'b0, 80, 0, 160, 160));
    steps.insert(steps.size(), box_step(1'b0, 40, 0, 160, 160));
    // threshold 0: any overlap at all suppresses, touching edges do not
    steps.insert(steps.size(), cfg_step(9'd0));
    steps.insert(steps.size(), known_step(1'b1, 0, 0, 160, 160, 1'b1, 0, 0));
    steps.insert(steps.size(), box_step(1'b0, 159, 159, 160, 160));
    steps.insert(steps.size(), box_step(1'b0, 160, 0, 160, 160));
    // threshold 256: even identical boxes survive
    steps.insert(steps.size(), cfg_step(9'd256));
    steps.insert(steps.size(), known_step(1'b1, 16, 16, 320, 320, 1'b1, 0, 0));
    steps.insert(steps.size(), box_step(1'b0, 16, 16, 320, 320));
    steps.insert(steps.size(), box_step(1'b0, -16, -16, 320, 320));
    // largest register value
    steps.insert(steps.size(), cfg_step(9'd511));
    steps.insert(steps.size(), known_step(1'b1, -32768, 32767, 32767, 32767, 1'b1, 0, 0));
    steps.insert(steps.size(), box_step(1'b0, -32768, 32767, 32767, 32767));
    steps.insert(steps.size(), box_step(1'b0, -1, -1, 1, 1));
    // back to default; frame start mid-stream restarts list and index
    steps.insert(steps.size(), cfg_step(THR_RESET));
    steps.insert(steps.size(), known_step(1'b1, -100, -100, 200, 200, 1'b1, 0, 0));
    steps.insert(steps.size(), known_step(1'b1, -100, -100, 200, 200, 1'b1, 0, 0));
    steps.insert(steps.size(), box_step(1'b0, -99, -100, 200, 200));

    foreach (steps[s]) begin
      if (steps[s].kind == STEP_CFG) set_threshold(steps[s].thr);
      else offer_box(steps[s].box, steps[s].known, steps[s].want);
    end

    // random frames: boxes jittered around a few cluster centers so that
    // overlaps are common, mixed with raw noise words
    for (p = 0; p < 7; p++) begin
      case (p)
        0:       thr = THR_RESET;
        1:       thr = 9'd0;
        2:       thr = 9'd256;
        3:       thr = 9'd511;
        4:       thr = 9'd60;
        5:       thr = 9'd200;
        default: thr = THR_W'($urandom_range(511));
      endcase
      set_threshold(thr);
      sent = 0;
      while (sent < PHASE_BOXES) begin
        nbox = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        ncl  = $urandom_range(1, 4);
        for (c = 0; c < ncl; c++) begin
          cx[c]  = int'($urandom_range(8000)) - 4000;
          cy[c]  = int'($urandom_range(8000)) - 4000;
          csz[c] = $urandom_range(32, 1200);
        end
        for (i = 0; i < nbox; i++) begin
          if ($urandom_range(99) < 12) begin
            // noise: every field over its whole range, frame start at random
            b = BOX_W'({$urandom, $urandom});
          end else begin
            c  = $urandom_range(ncl - 1);
            sz = csz[c];
            b.frame_start = (i == 0);
            b.x = CB'(cx[c] + int'($urandom_range(sz / 2)) - sz / 4);
            b.y = CB'(cy[c] + int'($urandom_range(sz / 2)) - sz / 4);
            b.w = ($urandom_range(19) == 0) ? '0 :
                  LW'(sz + int'($urandom_range(sz / 4)) - sz / 8);
            b.h = LW'(sz + int'($urandom_range(sz / 4)) - sz / 8);
          end
          offer_box(b, 1'b0, '0);
          sent++;
          // sender keeps offering while the receiver sits still
          if (p == 1 && sent == 40) hold_req = 1'b1;
        end
      end
    end

    // full store: 64 disjoint tiles fill it, then near copies of tiles are
    // dropped and boxes far away are reported kept but not stored
    set_threshold(THR_RESET);
    for (i = 0; i < MAX_KEPT + 16; i++) begin
      b.frame_start = (i == 0);
      if (i < MAX_KEPT) begin
        b.x = CB'((i % 8) * 400 - 1600);
        b.y = CB'((i / 8) * 400 - 1600);
        b.w = LW'(256);
        b.h = LW'(256);
      end else if ($urandom_range(1)) begin
        k   = $urandom_range(MAX_KEPT - 1);
        b.x = CB'((k % 8) * 400 - 1600 + int'($urandom_range(8)));
        b.y = CB'((k / 8) * 400 - 1600 + int'($urandom_range(8)));
        b.w = LW'($urandom_range(250, 262));
        b.h = LW'($urandom_range(250, 262));
      end else begin
        b.x = CB'(8000 + int'($urandom_range(20)) * 300);
        b.y = CB'(8000 + int'($urandom_range(20)) * 300);
        b.w = LW'($urandom_range(1, 400));
        b.h = LW'($urandom_range(1, 400));
      end
      offer_box(b, 1'b0, '0);
    end

    // a new frame starts counting from zero again
    set_threshold(THR_W'($urandom_range(511)));
    for (i = 0; i < 4; i++) begin
      b.frame_start = (i == 0);
      b.x = CB'($urandom_range(400));
      b.y = CB'($urandom_range(400));
      b.w = LW'($urandom_range(1, 400));
      b.h = LW'($urandom_range(1, 400));
      offer_box(b, 1'b0, '0);
    end

    // drain, then give stray words time to show up
    box_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
